FILE: sv/fdos_pkg.sv
// Shared types and constants of the drop-oldest FIFO with statistics.
`timescale 1ns / 1ps
package fdos_pkg;

  // operation selector carried on the input tuser
  typedef enum logic [1:0] {
    OP_ENQ    = 2'd0,
    OP_DEQ    = 2'd1,
    OP_STATUS = 2'd2
  } op_e;

  // sequencer states, one-hot
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_EMIT  = 3'b100
  } state_e;

  localparam int unsigned CAPACITY_DEFAULT = 255;
  localparam int unsigned DISC_W           = 32;
  localparam logic [DISC_W-1:0] DISC_MAX   = '1;

endpackage

FILE: sv/fdos_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module fdos_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/fdos_out_reg.sv
// Output register stage: holds one finished result until the sink takes it.
`timescale 1ns / 1ps
module fdos_out_reg #(
  parameter int unsigned DW = 8,
  parameter int unsigned UW = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [DW-1:0] data_i,
  input  logic [UW-1:0] user_i,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [DW-1:0] data_o,
  output logic [UW-1:0] user_o
);

  logic          valid_q;
  logic [DW-1:0] data_q;
  logic [UW-1:0] user_q;

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
      user_q <= user_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign user_o  = user_q;

endmodule

FILE: sv/fifo_drop_oldest_with_stats.sv
// Top level: drop-oldest FIFO of entry handles with discard and high-water statistics.
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+------------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready    | tdata: entry, clr_disc, clr_hw; tuser: op
//  m_axis   | out | m_axis_tvalid/tready    | tdata: result, head, depth, discards, hw;
//           |     |                         | tuser: result_valid, was_dropped
//  cfg      | in  | cfg_we_i (no wait)      | cfg_wdata_i: max capacity
//
// Sequencing: one item at a time. A transfer whose new head is already cached (status,
// empty dequeue, enqueue into a non-full queue, dequeue of the last entry, drop at
// capacity one) goes from S_IDLE straight to S_EMIT; one whose new head is an older
// held entry passes through S_FETCH first, since that entry is read through the
// registered read port of the entry RAM. S_EMIT waits while the output register stalls.
// Reset: all pointers, counts and statistics clear, capacity goes to 255 (clamped
// to QUEUE_DEPTH). The entry RAM is not cleared; only written entries are read.
// Stalls: the finished result sits in a staging set until the output register
// frees; the input side stays closed meanwhile.
`timescale 1ns / 1ps
module fifo_drop_oldest_with_stats
  import fdos_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 256,
  parameter int unsigned ENTRY_WIDTH = 32,
  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH),
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned IN_W   = ENTRY_WIDTH + 2,
  localparam int unsigned IN_TW  = ((IN_W + 7) / 8) * 8,
  localparam int unsigned OUT_W  = 2 * ENTRY_WIDTH + 2 * CNT_W + DISC_W,
  localparam int unsigned OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // [ENTRY_WIDTH-1:0] entry_data, then clear_discards, clear_high_water, zero pad
  input  logic [IN_TW-1:0]  s_axis_tdata,
  // [1:0] op
  input  logic [1:0]        s_axis_tuser,
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // result_entry, head_entry, depth, discard_count, high_water, zero pad
  output logic [OUT_TW-1:0] m_axis_tdata,
  // [0] result_valid, [1] was_dropped
  output logic [1:0]        m_axis_tuser,
  // capacity register
  input  logic              cfg_we_i,
  input  logic [CNT_W-1:0]  cfg_wdata_i
);

  localparam int unsigned CAP_RESET =
    (CAPACITY_DEFAULT > QUEUE_DEPTH) ? QUEUE_DEPTH : CAPACITY_DEFAULT;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) r = '0;
    else r = p + PTR_W'(1);
    return r;
  endfunction

  // state
  state_e                 st_q, st_d;
  logic [PTR_W-1:0]       head_ptr_q, head_ptr_d;
  logic [PTR_W-1:0]       tail_ptr_q, tail_ptr_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [CNT_W-1:0]       cap_q;
  logic [DISC_W-1:0]      disc_q, disc_d;
  logic [CNT_W-1:0]       peak_q, peak_d;
  logic [ENTRY_WIDTH-1:0] head_q, head_d;      // cached copy of the front entry

  // staged result fields (pre-clear statistics)
  logic [ENTRY_WIDTH-1:0] res_entry_q, res_entry_d;
  logic                   res_valid_q, res_valid_d;
  logic                   res_drop_q, res_drop_d;
  logic [DISC_W-1:0]      res_disc_q, res_disc_d;
  logic [CNT_W-1:0]       res_hw_q, res_hw_d;

  // RAM ports
  logic                   ram_we, ram_re;
  logic [PTR_W-1:0]       ram_raddr;
  logic [ENTRY_WIDTH-1:0] ram_rdata;

  // input fields
  op_e                    in_op;
  logic [ENTRY_WIDTH-1:0] in_data;
  logic                   in_clr_disc, in_clr_hw;
  logic                   in_xfer;
  logic                   full;
  logic [CNT_W-1:0]       new_count;
  logic [DISC_W-1:0]      disc_upd;
  logic [CNT_W-1:0]       peak_upd;

  // output side
  logic                   emit_ready;
  logic [OUT_W-1:0]       out_payload;
  logic [OUT_TW-1:0]      out_tdata;
  logic [ENTRY_WIDTH-1:0] head_view;

  assign in_op       = op_e'(s_axis_tuser);
  assign in_data     = s_axis_tdata[ENTRY_WIDTH-1:0];
  assign in_clr_disc = s_axis_tdata[ENTRY_WIDTH];
  assign in_clr_hw   = s_axis_tdata[ENTRY_WIDTH+1];

  assign s_axis_tready = (st_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // capacity is never below 1, so full implies a non-empty queue
  assign full = (count_q >= cap_q) && (count_q != '0);

  always_comb begin
    st_d        = st_q;
    head_ptr_d  = head_ptr_q;
    tail_ptr_d  = tail_ptr_q;
    count_d     = count_q;
    disc_d      = disc_q;
    peak_d      = peak_q;
    head_d      = head_q;
    res_entry_d = res_entry_q;
    res_valid_d = res_valid_q;
    res_drop_d  = res_drop_q;
    res_disc_d  = res_disc_q;
    res_hw_d    = res_hw_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = next_ptr(head_ptr_q);
    new_count   = count_q;
    disc_upd    = disc_q;
    peak_upd    = peak_q;

    unique case (st_q)
      S_IDLE: begin
        if (in_xfer) begin
          res_entry_d = '0;
          res_valid_d = 1'b0;
          res_drop_d  = 1'b0;
          st_d        = S_EMIT;
          case (in_op)
            OP_ENQ: begin
              ram_we     = 1'b1;
              tail_ptr_d = next_ptr(tail_ptr_q);
              if (full) begin
                // oldest goes out as the result, new entry goes in
                res_entry_d = head_q;
                res_valid_d = 1'b1;
                res_drop_d  = 1'b1;
                if (disc_q != DISC_MAX) disc_upd = disc_q + DISC_W'(1);
                head_ptr_d = next_ptr(head_ptr_q);
                if (count_q == CNT_W'(1)) begin
                  head_d = in_data;
                end else begin
                  ram_re = 1'b1;
                  st_d   = S_FETCH;
                end
              end else begin
                new_count = count_q + CNT_W'(1);
                if (count_q == '0) head_d = in_data;
              end
              if (new_count > peak_q) peak_upd = new_count;
            end
            OP_DEQ: begin
              if (count_q != '0) begin
                res_entry_d = head_q;
                res_valid_d = 1'b1;
                head_ptr_d  = next_ptr(head_ptr_q);
                new_count   = count_q - CNT_W'(1);
                if (count_q != CNT_W'(1)) begin
                  ram_re = 1'b1;
                  st_d   = S_FETCH;
                end
              end
            end
            default: ; // status query, unused code too
          endcase
          count_d    = new_count;
          res_disc_d = disc_upd;
          res_hw_d   = peak_upd;
          disc_d     = in_clr_disc ? '0 : disc_upd;
          peak_d     = in_clr_hw ? '0 : peak_upd;
        end
      end
      S_FETCH: begin
        head_d = ram_rdata;
        st_d   = S_EMIT;
      end
      S_EMIT: begin
        if (emit_ready) st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_IDLE;
      head_ptr_q <= '0;
      tail_ptr_q <= '0;
      count_q    <= '0;
      disc_q     <= '0;
      peak_q     <= '0;
      cap_q      <= CNT_W'(CAP_RESET);
    end else begin
      st_q       <= st_d;
      head_ptr_q <= head_ptr_d;
      tail_ptr_q <= tail_ptr_d;
      count_q    <= count_d;
      disc_q     <= disc_d;
      peak_q     <= peak_d;
      // capacity only changes on an empty queue; zero and oversize are clamped
      if (cfg_we_i && (count_q == '0)) begin
        if (cfg_wdata_i == '0) cap_q <= CNT_W'(1);
        else if (cfg_wdata_i > CNT_W'(QUEUE_DEPTH)) cap_q <= CNT_W'(QUEUE_DEPTH);
        else cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    head_q      <= head_d;
    res_entry_q <= res_entry_d;
    res_valid_q <= res_valid_d;
    res_drop_q  <= res_drop_d;
    res_disc_q  <= res_disc_d;
    res_hw_q    <= res_hw_d;
  end

  fdos_ram #(
    .WIDTH (ENTRY_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_ptr_q),
    .wdata_i (in_data),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // queue state is frozen while in S_EMIT, so head and depth read live
  assign head_view   = (count_q != '0) ? head_q : '0;
  assign out_payload = {res_hw_q, res_disc_q, count_q, head_view, res_entry_q};
  assign out_tdata   = OUT_TW'(out_payload);

  fdos_out_reg #(
    .DW (OUT_TW),
    .UW (2)
  ) u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (st_q == S_EMIT),
    .ready_o (emit_ready),
    .data_i  (out_tdata),
    .user_i  ({res_drop_q, res_valid_q}),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (m_axis_tdata),
    .user_o  (m_axis_tuser)
  );

  // ---------------------------------------------------------------------------
  // assertions

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(st_q))
    else $error("sequencer state not one-hot");

  a_count_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cap_q)
    else $error("queue depth above capacity");

  a_fetch_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_FETCH) |-> ($past(st_q) == S_IDLE))
    else $error("head fetch not started by a transfer");

  a_drop_has_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tuser[0])
    else $error("dropped flag without a result entry");

  a_fetch_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_FETCH) |-> (count_q != '0))
    else $error("head fetch on an empty queue");

endmodule

FILE: bench/fifo_drop_oldest_with_stats_test.sv
// Self-checking testbench for the drop-oldest FIFO with discard and high-water statistics.
`timescale 1ns / 1ps
module fifo_drop_oldest_with_stats_test
  import fdos_pkg::*;
();

  localparam int unsigned QDEPTH   = 256;
  localparam int unsigned IN_TW    = 40;   // 32 entry + 2 clear flags, padded to bytes
  localparam int unsigned OUT_TW   = 120;  // 32+32+9+32+9 = 114, padded to bytes
  localparam int unsigned IDLE_CAP = 2000; // cycles without any transfer before giving up
  localparam int unsigned SETTLE   = 6;    // worst case latency plus margin, in cycles

  // op code 3 is not decoded by the block and behaves as a status query
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // one result transfer, unpacked from m_axis
  typedef struct packed {
    logic [31:0] entry;
    logic        valid;
    logic        dropped;
    logic [31:0] head;
    logic [8:0]  depth;
    logic [31:0] discards;
    logic [8:0]  peak;
  } queue_report_t;

  localparam queue_report_t NO_REPORT = '0;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e     kind;
    logic [1:0]    op;
    logic [31:0]   data;
    logic          clr_disc;
    logic          clr_hw;
    logic [8:0]    cap;
    bit            typed;   // use the report below instead of the predictor
    queue_report_t want;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_TW-1:0]  s_axis_tdata = '0;  // entry_data, clear_discards, clear_high_water, pad
  logic [1:0]        s_axis_tuser = '0;  // op
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_TW-1:0] m_axis_tdata;       // result, head, depth, discards, high water, pad
  logic [1:0]        m_axis_tuser;       // result_valid, was_dropped
  logic              cfg_we_i = 1'b0;
  logic [8:0]        cfg_wdata_i = '0;

  fifo_drop_oldest_with_stats dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor: a mirror of the queue, its pointers and its statistics
  // ---------------------------------------------------------------------------
  logic [31:0] q_store [QDEPTH];
  logic [7:0]  q_head = '0;         // 8-bit pointers wrap at 256 by themselves
  logic [7:0]  q_tail = '0;
  int unsigned q_count = 0;
  logic [31:0] q_drops = '0;
  int unsigned q_peak = 0;
  int unsigned q_capacity = CAPACITY_DEFAULT;

  queue_report_t pending_reports [$];  // expected results, oldest first

  int unsigned mismatch_count = 0;
  int unsigned items_in = 0;
  int unsigned reports_out = 0;
  int unsigned drops_seen = 0;
  int unsigned deepest_seen = 0;
  int unsigned idle_cycles = 0;
  bit          idle_en = 1'b1;        // random gaps and stalls allowed
  int unsigned stall_left = 0;

  // Apply one accepted operation to the mirror and return the report it produces.
  function automatic queue_report_t advance_queue(logic [1:0] op, logic [31:0] data,
                                                  logic clr_disc, logic clr_hw);
    queue_report_t r = '0;
    if (op == OP_ENQ) begin
      // full queue: the oldest entry goes out first
      if (q_count >= q_capacity && q_count != 0) begin
        r.entry   = q_store[q_head];
        r.valid   = 1'b1;
        r.dropped = 1'b1;
        q_head    = q_head + 8'd1;
        q_count   = q_count - 1;
        if (q_drops != DISC_MAX) q_drops = q_drops + 32'd1;
      end
      q_store[q_tail] = data;
      q_tail  = q_tail + 8'd1;
      q_count = q_count + 1;
      if (q_count > q_peak) q_peak = q_count;
    end else if (op == OP_DEQ) begin
      if (q_count != 0) begin
        r.entry = q_store[q_head];
        r.valid = 1'b1;
        q_head  = q_head + 8'd1;
        q_count = q_count - 1;
      end
    end
    if (q_count != 0) r.head = q_store[q_head];
    r.depth    = q_count[8:0];
    r.discards = q_drops;
    r.peak     = q_peak[8:0];
    // statistics are reported first, cleared afterwards
    if (clr_disc) q_drops = '0;
    if (clr_hw) q_peak = 0;
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      flag_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                              reports_out, name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, driven at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (idle_en && stall_left > 0) begin
      m_axis_tready = 1'b0;
      stall_left--;
    end else if (rst_ni && idle_en && $urandom_range(0, 7) == 0) begin
      m_axis_tready = 1'b0;
      stall_left = $urandom_range(1, 10) - 1;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // Checker: every result transfer is matched against the oldest expectation.
  always @(posedge clk_i) begin
    queue_report_t got;
    queue_report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.entry    = m_axis_tdata[31:0];
      got.head     = m_axis_tdata[63:32];
      got.depth    = m_axis_tdata[72:64];
      got.discards = m_axis_tdata[104:73];
      got.peak     = m_axis_tdata[113:105];
      got.valid    = m_axis_tuser[0];
      got.dropped  = m_axis_tuser[1];
      if (pending_reports.size() == 0) begin
        flag_mismatch($sformatf("result with nothing expected: 0x%0h", got));
      end else begin
        want = pending_reports.pop_front();
        check_field("result_entry", got.entry, want.entry);
        check_field("result_valid", 32'(got.valid), 32'(want.valid));
        check_field("was_dropped", 32'(got.dropped), 32'(want.dropped));
        check_field("head_entry", got.head, want.head);
        check_field("depth", 32'(got.depth), 32'(want.depth));
        check_field("discard_count", got.discards, want.discards);
        check_field("high_water", 32'(got.peak), 32'(want.peak));
      end
      reports_out++;
      if (got.dropped) drops_seen++;
      if (got.depth > deepest_seen) deepest_seen = got.depth;
    end
  end

  // Watchdog: any transfer on either side resets the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_CAP) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_CAP);
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Offer one operation and wait for its transfer. tvalid stays high on return,
  // so back-to-back calls keep an operation offered, apart from random gaps.
  task automatic push_item(logic [1:0] op, logic [31:0] data, logic clr_disc, logic clr_hw,
                           bit typed, queue_report_t want);
    queue_report_t r;
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    s_axis_tdata  = {6'b0, clr_hw, clr_disc, data};
    s_axis_tuser  = op;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    r = advance_queue(op, data, clr_disc, clr_hw);
    pending_reports.insert(pending_reports.size(), typed ? want : r);
    items_in++;
  endtask

  // Capacity write: the sender holds off until every result is back, then
  // waits out the pipeline before the write so the block is truly idle.
  task automatic write_capacity(logic [8:0] value);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    // ignored while entries are held; zero means one, above depth means depth
    if (q_count == 0)
      q_capacity = (value == 0) ? 1 : ((value > QDEPTH) ? QDEPTH : value);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Random operations with the given enqueue and dequeue shares in percent;
  // the remainder are status queries, now and then on the unused op code.
  task automatic run_burst(int unsigned n, int unsigned enq_pct, int unsigned deq_pct);
    int unsigned r;
    logic [1:0]  op;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < enq_pct) op = OP_ENQ;
      else if (r < enq_pct + deq_pct) op = OP_DEQ;
      else if ($urandom_range(0, 3) == 0) op = OP_UNUSED;
      else op = OP_STATUS;
      push_item(op, pick_word(), $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
                1'b0, NO_REPORT);
    end
  endtask

  // Mostly dequeues until the mirror says the queue is empty.
  task automatic drain_queue();
    while (q_count != 0) run_burst(1, 5, 90);
  endtask

  // ---------------------------------------------------------------------------
  // Directed stimulus. Reset capacity is 255. Rows with a typed report are
  // obvious from the spec; the rest go through the predictor.
  // ---------------------------------------------------------------------------
  stim_row_t directed_rows [0:23] = '{
    // empty queue: status, dequeue (clears on zero stats), unused op
    '{ROW_ITEM, OP_STATUS, 32'h0, 1'b0, 1'b0, 9'd0, 1'b1, NO_REPORT},
    '{ROW_ITEM, OP_DEQ, 32'hdead_beef, 1'b1, 1'b1, 9'd0, 1'b1, NO_REPORT},
    '{ROW_ITEM, OP_UNUSED, 32'hffff_ffff, 1'b0, 1'b0, 9'd0, 1'b1, NO_REPORT},
    // extremes of the entry field
    '{ROW_ITEM, OP_ENQ, 32'h0, 1'b0, 1'b0, 9'd0, 1'b1,
      '{32'h0, 1'b0, 1'b0, 32'h0, 9'd1, 32'd0, 9'd1}},
    '{ROW_ITEM, OP_ENQ, 32'hffff_ffff, 1'b0, 1'b0, 9'd0, 1'b1,
      '{32'h0, 1'b0, 1'b0, 32'h0, 9'd2, 32'd0, 9'd2}},
    '{ROW_ITEM, OP_DEQ, 32'h0, 1'b0, 1'b0, 9'd0, 1'b1,
      '{32'h0, 1'b1, 1'b0, 32'hffff_ffff, 9'd1, 32'd0, 9'd2}},
    // capacity write with an entry held must be ignored
    '{ROW_CFG, OP_STATUS, 32'h0, 1'b0, 1'b0, 9'd1, 1'b0, NO_REPORT},
    '{ROW_ITEM, OP_ENQ, 32'h5a5a_5a5a, 1'b0, 1'b0, 9'd0, 1'b0, NO_REPORT},
    '{ROW_ITEM, OP_DEQ, 32'h0, 1'b0, 1'b0, 9'd0, 1'b0, NO_REPORT},
    '{ROW_ITEM, OP_DEQ, 32'h0, 1'b0, 1'b0, 9'd0, 1'b0, NO_REPORT},
    '{ROW_ITEM, OP_DEQ, 32'h0, 1'b0, 1'b0, 9'd0, 1'b1,
      '{32'h0, 1'b0, 1'b0, 32'h0, 9'd0, 32'd0, 9'd2}},
    // capacity zero acts as one: each enqueue onto a held entry drops the oldest
    '{ROW_CFG, OP_STATUS, 32'h0, 1'b0, 1'b0, 9'd0, 1'b0, NO_REPORT},
    '{ROW_ITEM, OP_ENQ, 32'h1234_5678, 1'b0, 1'b0, 9'd0, 1'b1,
      '{32'h0, 1'b0, 1'b0, 32'h1234_5678, 9'd1, 32'd0, 9'd2}},
    '{ROW_ITEM, OP_ENQ, 32'ha5a5_a5a5, 1'b0, 1'b0, 9'd0, 1'b1,
      '{32'h1234_5678, 1'b1, 1'b1, 32'ha5a5_a5a5, 9'd1, 32'd1, 9'd2}},
    '{ROW_ITEM, OP_ENQ, 32'h8000_0001, 1'b1, 1'b0, 9'd0, 1'b1,
      '{32'ha5a5_a5a5, 1'b1, 1'b1, 32'h8000_0001, 9'd1, 32'd2, 9'd2}},
    '{ROW_ITEM, OP_STATUS, 32'h0, 1'b0, 1'b1, 9'd0, 1'b0, NO_REPORT},
    '{ROW_ITEM, OP_STATUS, 32'h0, 1'b0, 1'b0, 9'd0, 1'b0, NO_REPORT},
    '{ROW_ITEM, OP_DEQ, 32'h0, 1'b0, 1'b0, 9'd0, 1'b1,
      '{32'h8000_0001, 1'b1, 1'b0, 32'h0, 9'd0, 32'd0, 9'd0}},
    // all ones in the register clamps to the full depth
    '{ROW_CFG, OP_STATUS, 32'h0, 1'b0, 1'b0, 9'h1ff, 1'b0, NO_REPORT},
    '{ROW_ITEM, OP_ENQ, 32'h0000_ffff, 1'b0, 1'b0, 9'd0, 1'b0, NO_REPORT},
    '{ROW_ITEM, OP_ENQ, 32'hffff_0000, 1'b1, 1'b1, 9'd0, 1'b0, NO_REPORT},
    '{ROW_ITEM, OP_UNUSED, 32'h0, 1'b0, 1'b0, 9'd0, 1'b0, NO_REPORT},
    '{ROW_CFG, OP_STATUS, 32'h0, 1'b0, 1'b0, 9'd2, 1'b0, NO_REPORT},
    '{ROW_ITEM, OP_DEQ, 32'h0, 1'b0, 1'b0, 9'd0, 1'b0, NO_REPORT}
  };

  // capacity settings for the random phases; the last is replaced at random
  logic [8:0] phase_caps [0:7] = '{9'd2, 9'd0, 9'd3, 9'd256, 9'd255, 9'd300, 9'd1, 9'd0};

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        write_capacity(directed_rows[i].cap);
      else
        push_item(directed_rows[i].op, directed_rows[i].data, directed_rows[i].clr_disc,
                  directed_rows[i].clr_hw, directed_rows[i].typed, directed_rows[i].want);
    end

    // Capacity is the full depth here: fill well past it so the ring pointers
    // wrap and overflow drops happen at 256 entries, then empty it again.
    run_burst(280, 97, 2);
    drain_queue();

    phase_caps[7] = $urandom_range(4, 40);
    foreach (phase_caps[i]) begin
      write_capacity(phase_caps[i]);
      run_burst(40, 55, 35);
      drain_queue();
    end

    // closing stretch without gaps or stalls
    idle_en = 1'b0;
    write_capacity($urandom_range(1, 8));
    run_burst(80, 50, 40);

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE * 2) @(posedge clk_i);

    $display("run covered %0d operations in, %0d results out, %0d overflow drops",
             items_in, reports_out, drops_seen);
    $display("capacities 1 to 256 incl. clamped writes, deepest queue seen %0d, %0d mismatches",
             deepest_seen, mismatch_count);
    if (mismatch_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

FILE: filelist.f
sv/fdos_pkg.sv
sv/fdos_ram.sv
sv/fdos_out_reg.sv
sv/fifo_drop_oldest_with_stats.sv
bench/fifo_drop_oldest_with_stats_test.sv
